FILE: sv/mam_pkg.sv
// ----------------------------------------------------------------------------
// mam_pkg: shared types and constants for the 3x3 matrix add / multiply block
// Sizes, the store write bundle and the job descriptor passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package mam_pkg;

	localparam int DIM        = 3;
	localparam int ELEM_W     = 16;
	localparam int CELLS      = DIM * DIM;
	localparam int ADDR_W     = $clog2(2 * CELLS);
	localparam int IDX_W      = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int VAL_W      = 33;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int ROW_W      = 2;
	localparam int COL_W      = 2;
	localparam int IN_TDATA_W = ((ELEM_W + 7) / 8) * 8;
	localparam int OUT_USED_W = VAL_W + ROW_W + COL_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_USED_W;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_MUL = 1'b1;

	// one write into the element store
	typedef struct packed {
		logic              en;
		logic              sel_b;
		logic [ADDR_W-1:0] addr;
		logic [ELEM_W-1:0] data;
	} wr_t;

	// one loaded matrix pair ready for computation
	typedef struct packed {
		logic bank;
		logic mode;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_push_t;

	typedef struct packed {
		logic head_valid;
		logic full;
		job_t head;
	} jobq_stat_t;

endpackage

`default_nettype wire

FILE: sv/mam_front.sv
// ----------------------------------------------------------------------------
// mam_front: element intake
// Count incoming elements, steer them into the A or B half of the current
// bank, and post a job once the second matrix of a pair is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_front
	import mam_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ELEM_W-1:0] in_elem,
	input  wire logic              mode,
	input  wire jobq_stat_t        q_stat,
	output wr_t                    wr,
	output job_push_t              push
);

	localparam logic [ADDR_W-1:0] CELLS_A = ADDR_W'(CELLS);
	localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(2 * CELLS - 1);

	logic [ADDR_W-1:0] pos_q;
	logic              bank_q;
	logic              take;
	logic              in_b;
	logic [ADDR_W-1:0] base;

	assign in_ready = !q_stat.full;
	assign take     = in_valid && in_ready;
	assign in_b     = (pos_q >= CELLS_A);
	assign base     = bank_q ? CELLS_A : '0;

	always_comb begin
		wr.en    = take;
		wr.sel_b = in_b;
		wr.data  = in_elem;
		wr.addr  = in_b ? (base + pos_q - CELLS_A) : (base + pos_q);
	end

	assign push.valid    = take && (pos_q == LAST_A);
	assign push.job.bank = bank_q;
	assign push.job.mode = mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			bank_q <= 1'b0;
		end else if (take) begin
			if (pos_q == LAST_A) begin
				pos_q  <= '0;
				bank_q <= !bank_q;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/mam_jobq.sv
// ----------------------------------------------------------------------------
// mam_jobq: two-entry job queue
// Holds loaded pairs between intake and compute; an entry stays until the
// compute side has read its bank completely.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_jobq
	import mam_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire job_push_t push,
	input  wire logic      pop,
	output jobq_stat_t     stat
);

	job_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign stat.head_valid = (cnt_q != 2'd0);
	assign stat.full       = (cnt_q == 2'd2);
	assign stat.head       = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wp_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/mam_back.sv
// ----------------------------------------------------------------------------
// mam_back: compute side
// Element store for two banks, a sequencer over result entries, one
// multiply/add stage with accumulator, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_back
	import mam_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire wr_t        wr,
	input  wire jobq_stat_t q_stat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [VAL_W-1:0] out_value,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic            out_last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam logic [ADDR_W-1:0] DIM_A   = ADDR_W'(DIM);
	localparam logic [ADDR_W-1:0] CELLS_A = ADDR_W'(CELLS);
	localparam logic [IDX_W-1:0]  IDX_MAX = IDX_W'(DIM - 1);

	logic [ELEM_W-1:0] mem_a [2 * CELLS];
	logic [ELEM_W-1:0] mem_b [2 * CELLS];

	logic [1:0]       state_q;
	logic [IDX_W-1:0] r_q;
	logic [IDX_W-1:0] c_q;
	logic [IDX_W-1:0] k_q;
	logic             mode_q;
	logic             bank_q;
	logic             done_q;

	logic              issue;
	logic              issue_first;
	logic              issue_last;
	logic              load_out;
	logic              last_ent;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;

	logic                     v_s1, first_s1, last_s1;
	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic                     v_s2, first_s2, last_s2;
	logic signed [VAL_W-1:0]  val_s2;
	logic signed [PROD_W-1:0] prod;
	logic signed [VAL_W-1:0]  acc_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_last_q;

	// store: one write port from intake, one registered read port per matrix
	always_ff @(posedge clk) begin
		if (wr.en && !wr.sel_b) begin
			mem_a[wr.addr] <= wr.data;
		end
		if (wr.en && wr.sel_b) begin
			mem_b[wr.addr] <= wr.data;
		end
		a_s1 <= mem_a[rd_addr_a];
		b_s1 <= mem_b[rd_addr_b];
	end

	assign base = bank_q ? CELLS_A : '0;

	always_comb begin
		if (mode_q == MODE_MUL) begin
			rd_addr_a = base + ADDR_W'(r_q) * DIM_A + ADDR_W'(k_q);
			rd_addr_b = base + ADDR_W'(k_q) * DIM_A + ADDR_W'(c_q);
		end else begin
			rd_addr_a = base + ADDR_W'(r_q) * DIM_A + ADDR_W'(c_q);
			rd_addr_b = rd_addr_a;
		end
	end

	assign issue       = (state_q == ST_ISSUE);
	assign issue_first = (k_q == '0);
	assign issue_last  = (mode_q == MODE_ADD) || (k_q == IDX_MAX);
	assign last_ent    = (r_q == IDX_MAX) && (c_q == IDX_MAX);
	assign load_out    = (state_q == ST_DRAIN) && done_q && (!out_valid_q || out_ready);
	assign pop         = load_out && last_ent;

	// product or sum, then accumulate over the dot-product terms
	assign prod = a_s1 * b_s1;

	always_ff @(posedge clk) begin
		if (mode_q == MODE_MUL) begin
			val_s2 <= VAL_W'(prod);
		end else begin
			val_s2 <= VAL_W'(a_s1) + VAL_W'(b_s1);
		end
		if (v_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + val_s2;
		end
		if (load_out) begin
			out_value_q <= acc_q;
			out_row_q   <= ROW_W'(r_q);
			out_col_q   <= COL_W'(c_q);
			out_last_q  <= last_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			v_s1     <= issue;
			first_s1 <= issue_first;
			last_s1  <= issue_last;
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	// sequencer: one entry in flight, advance once its result is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			mode_q      <= MODE_MUL;
			bank_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (v_s2 && last_s2) begin
				done_q <= 1'b1;
			end else if (load_out) begin
				done_q <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_stat.head_valid) begin
						mode_q  <= q_stat.head.mode;
						bank_q  <= q_stat.head.bank;
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (load_out) begin
						k_q <= '0;
						if (last_ent) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
							if (c_q == IDX_MAX) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

FILE: sv/matrix_add_multiply_3x3_top.sv
// ----------------------------------------------------------------------------
// matrix_add_multiply_3x3_top: streaming 3x3 matrix adder / multiplier
// Loads A then B from an element stream and returns A+B or A*B row-major.
// ----------------------------------------------------------------------------
// Signed 16-bit elements arrive on the slave stream, nine for matrix A and
// then nine for matrix B, both row-major. Once the eighteenth element of a pair
// is accepted, the block returns nine 33-bit exact results on the master
// stream, row-major, each tagged with its row and column; tlast marks the
// final entry. The mode register (reset value 1) picks elementwise addition
// (0) or the matrix product (1); it is sampled when the last element of B is
// transferred, and should be written only while the block is idle. Elements
// are taken one per cycle while the two-entry job queue has room: the store
// holds two banks, so one pair can load while the previous one computes, and
// s_axis_tready drops only when both banks wait for the compute side. Each
// result entry goes through a single multiply-accumulate unit: a product
// entry issues three multiply steps and a sum entry one add step, each
// through the read, multiply and accumulate registers. The result sits in an
// output register, so the compute side keeps working on the next entry while
// a finished one waits for its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_add_multiply_3x3_top
	import mam_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration: operation_mode (0 add, 1 multiply)
	input  wire logic                   cfg_wr_en,
	input  wire logic                   cfg_wr_data,
	// element stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] element_value
	// result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // [32:0] result_value,
	                                                   // [34:33] result_row,
	                                                   // [36:35] result_column,
	                                                   // [39:37] zero
	output logic                        m_axis_tlast   // last_entry
);

	logic       mode_q;
	wr_t        wr;
	job_push_t  push;
	jobq_stat_t q_stat;
	logic       pop;

	logic [VAL_W-1:0] res_value;
	logic [ROW_W-1:0] res_row;
	logic [COL_W-1:0] res_col;

	// mode register: hold until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MUL;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// front: accept elements, write the store, post a job per complete pair
	mam_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_elem  (s_axis_tdata[ELEM_W-1:0]),
		.mode     (mode_q),
		.q_stat   (q_stat),
		.wr       (wr),
		.push     (push)
	);

	// queue: decouple intake from compute, one entry per loaded bank
	mam_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (q_stat)
	);

	// back: step through result entries and drive the result transfer
	mam_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (res_value),
		.out_row   (res_row),
		.out_col   (res_col),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_col, res_row, res_value};

	// a pair must never be posted while both banks are still in use
	assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (!q_stat.full || pop))
		else $error("job posted into a full queue");

	// a bank is released only when a job is actually outstanding
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.head_valid)
		else $error("job released from an empty queue");

	// the final entry of a result matrix sits at the last row and column
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
			(res_row == ROW_W'(DIM - 1) && res_col == COL_W'(DIM - 1)))
		else $error("last entry flagged away from the corner");

endmodule

`default_nettype wire

FILE: verif/matrix_add_multiply_3x3_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_add_multiply_3x3_top_test: self-checking bench for the 3x3 add / mul
// Streams matrix pairs into the block and checks every result entry against a
// predictor that rebuilds A and B from the accepted element transfers.
// ----------------------------------------------------------------------------

module matrix_add_multiply_3x3_top_test;

	import mam_pkg::*;

	localparam int PAIR_ELEMS    = 2 * CELLS;
	localparam int TARGET_ELEMS  = 430;
	localparam int SETTLE_CYCLES = 64;   // quiet cycles ahead of a mode write
	localparam int TAIL_CYCLES   = 80;
	localparam int RUN_LIMIT_NS  = 2000000;

	// what the driver does with one entry of the feed
	typedef enum logic {
		FEED_ELEMENT,
		FEED_MODE_WRITE
	} feed_kind_t;

	typedef struct {
		feed_kind_t        kind;
		logic [ELEM_W-1:0] value;   // element, or the new mode in bit 0
		int unsigned       gap;     // idle cycles before the element is offered
	} feed_entry_t;

	typedef enum logic [2:0] {
		DRV_FETCH,
		DRV_GAP,
		DRV_SEND,
		DRV_DRAIN,
		DRV_SETTLE,
		DRV_DONE
	} feed_state_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic                    last;
	} result_entry_t;

	// clock, reset and block ports; every input is known from time zero
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic                   cfg_wr_data = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [15:0] element_value
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [32:0] value, [34:33] row,
	                                              // [36:35] column, [39:37] zero
	logic                   m_axis_tlast;         // last_entry

	// stimulus feed and driver state
	feed_entry_t element_feed[$];
	feed_entry_t cur_feed = '{FEED_ELEMENT, '0, 0};
	feed_state_t drv_state = DRV_FETCH;
	int unsigned wait_left = 0;
	logic        mode_write_now;

	// predictor: shadow of the mode register and of the matrix pair being loaded
	logic                     mode_reg = MODE_MUL;
	logic signed [ELEM_W-1:0] mat_a[CELLS];
	logic signed [ELEM_W-1:0] mat_b[CELLS];
	int unsigned              loaded_count = 0;
	result_entry_t            awaited_entries[$];

	// result side
	int unsigned   stall_left = 0;
	logic          rx_quiet = 1'b0;
	result_entry_t got_entry;
	result_entry_t want_entry;
	int unsigned   mismatch_count = 0;

	matrix_add_multiply_3x3_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string field, input longint got, input longint want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
	endtask

	task automatic queue_element(input logic [ELEM_W-1:0] value, input logic quiet);
		element_feed.push_back('{FEED_ELEMENT, value, quiet ? 0 : $urandom_range(0, 9)});
	endtask

	// Work out all nine entries of A+B or A*B from the shadow matrices and the
	// mode in force at the transfer of the last element of B.
	task automatic predict_result_matrix();
		longint        acc;
		result_entry_t entry;
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				if (mode_reg == MODE_ADD) begin
					acc = longint'(mat_a[r * DIM + c]) + longint'(mat_b[r * DIM + c]);
				end else begin
					acc = 0;
					for (int k = 0; k < DIM; k++)
						acc += longint'(mat_a[r * DIM + k]) * longint'(mat_b[k * DIM + c]);
				end
				entry.value = acc[VAL_W-1:0];
				entry.row   = r[ROW_W-1:0];
				entry.col   = c[COL_W-1:0];
				entry.last  = (r == DIM - 1) && (c == DIM - 1);
				awaited_entries.push_back(entry);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: walk the feed, offer elements after their idle gap, and before a
	// mode write hold off until every awaited entry is back and the block has
	// had time to settle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			mode_write_now = 1'b0;
			// the element on the bus went through at this edge: advance
			if (drv_state == DRV_SEND && s_axis_tready)
				drv_state = DRV_FETCH;
			case (drv_state)
			DRV_FETCH: begin
				if (element_feed.size() == 0) begin
					drv_state = DRV_DONE;
				end else begin
					cur_feed = element_feed.pop_front();
					if (cur_feed.kind == FEED_MODE_WRITE) begin
						drv_state = DRV_DRAIN;
					end else begin
						wait_left = cur_feed.gap;
						drv_state = (wait_left == 0) ? DRV_SEND : DRV_GAP;
					end
				end
			end
			DRV_GAP: begin
				wait_left--;
				if (wait_left == 0)
					drv_state = DRV_SEND;
			end
			DRV_DRAIN: begin
				if (awaited_entries.size() == 0) begin
					wait_left = SETTLE_CYCLES;
					drv_state = DRV_SETTLE;
				end
			end
			DRV_SETTLE: begin
				if (awaited_entries.size() != 0) begin
					drv_state = DRV_DRAIN;
				end else if (wait_left == 0) begin
					mode_write_now = 1'b1;
					drv_state = DRV_FETCH;
				end else begin
					wait_left--;
				end
			end
			default: ;
			endcase
			s_axis_tvalid <= (drv_state == DRV_SEND);
			s_axis_tdata  <= cur_feed.value;
			cfg_wr_en     <= mode_write_now;
			cfg_wr_data   <= cur_feed.value[0];
		end
	end

	// ------------------------------------------------------------------------
	// Input monitor: track mode writes and element transfers, rebuild A then B,
	// and predict the result matrix once the eighteenth element is in.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				mode_reg = cfg_wr_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (loaded_count < CELLS)
					mat_a[loaded_count] = s_axis_tdata[ELEM_W-1:0];
				else
					mat_b[loaded_count - CELLS] = s_axis_tdata[ELEM_W-1:0];
				loaded_count++;
				if (loaded_count == PAIR_ELEMS) begin
					loaded_count = 0;
					predict_result_matrix();
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: stall at random between transfers, with quiet stretches,
	// and compare each transfer with the oldest awaited entry.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_entry.value = m_axis_tdata[VAL_W-1:0];
				got_entry.row   = m_axis_tdata[VAL_W +: ROW_W];
				got_entry.col   = m_axis_tdata[VAL_W + ROW_W +: COL_W];
				got_entry.last  = m_axis_tlast;
				if (awaited_entries.size() == 0) begin
					report_mismatch("unexpected result, value", got_entry.value, 0);
				end else begin
					want_entry = awaited_entries.pop_front();
					if (got_entry.value !== want_entry.value)
						report_mismatch("result_value", got_entry.value, want_entry.value);
					if (got_entry.row !== want_entry.row)
						report_mismatch("result_row", got_entry.row, want_entry.row);
					if (got_entry.col !== want_entry.col)
						report_mismatch("result_column", got_entry.col, want_entry.col);
					if (got_entry.last !== want_entry.last)
						report_mismatch("last_entry", got_entry.last, want_entry.last);
				end
				stall_left = rx_quiet ? 0 : $urandom_range(0, 9);
				if ($urandom_range(0, 39) == 0)
					rx_quiet = ~rx_quiet;
			end else if (stall_left != 0) begin
				stall_left--;
			end
			m_axis_tready <= (stall_left == 0);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned       total;
		int unsigned       phase_len;
		int unsigned       phase_no;
		logic              quiet;
		logic [ELEM_W-1:0] value;

		// Directed pair, multiply mode from reset. Row 0 of A against column 0
		// of B gives the largest product sum, against column 1 the smallest;
		// the last row mixes zero and the small signed values.
		for (int i = 0; i < DIM; i++) queue_element(16'h8000, 1'b0);
		for (int i = 0; i < DIM; i++) queue_element(16'h7FFF, 1'b0);
		queue_element(16'h0000, 1'b0);
		queue_element(16'hFFFF, 1'b0);
		queue_element(16'h0001, 1'b0);
		for (int i = 0; i < DIM; i++) begin
			queue_element(16'h8000, 1'b0);
			queue_element(16'h7FFF, 1'b0);
			queue_element(16'hFFFF, 1'b0);
		end
		total = PAIR_ELEMS;

		// Random phases, each opened by a mode write. Some phases end in the
		// middle of a pair, so the mode also changes while A or B is loading.
		phase_no = 0;
		while (total < TARGET_ELEMS) begin
			case (phase_no)
			0: value = ELEM_W'(MODE_ADD);
			1: value = ELEM_W'(MODE_MUL);
			default: value = ELEM_W'($urandom_range(0, 1));
			endcase
			element_feed.push_back('{FEED_MODE_WRITE, value, 0});
			quiet = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(0, 1) ? PAIR_ELEMS * $urandom_range(1, 3)
			                                 : $urandom_range(1, 60);
			// stop at the element budget
			if (phase_len > TARGET_ELEMS - total)
				phase_len = TARGET_ELEMS - total;
			repeat (phase_len) begin
				case ($urandom_range(0, 7))
				0: value = 16'h8000;
				1: value = 16'h7FFF;
				2: value = 16'h0000;
				3: value = 16'hFFFF;
				default: value = ELEM_W'($urandom_range(0, 16'hFFFF));
				endcase
				queue_element(value, quiet);
			end
			total += phase_len;
			phase_no++;
		end
		// close the last pair so its results come out too
		while (total % PAIR_ELEMS != 0) begin
			queue_element(ELEM_W'($urandom_range(0, 16'hFFFF)), 1'b0);
			total++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (!(drv_state == DRV_DONE && awaited_entries.size() == 0));
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("matrix_add_multiply_3x3_top_test OK");
		else
			$display("matrix_add_multiply_3x3_top_test NOT OK");
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#RUN_LIMIT_NS;
		$display("timeout with %0d result entries outstanding", awaited_entries.size());
		$display("matrix_add_multiply_3x3_top_test NOT OK");
		$finish;
	end

endmodule
